>>> hdl/tgcg_pkg.sv
package tgcg_pkg;

  localparam int FONT_HEIGHT     = 16;
  localparam int FONT_WIDTH      = 8;
  localparam int COLUMNS_PER_ROW = 16;

  // Page rows advanced by one text row.
  localparam logic [7:0] PAGE_STEP = 8'(FONT_HEIGHT / 8);

  localparam logic [4:0] COLUMN_LIMIT = 5'(COLUMNS_PER_ROW);

  // Code point ranges of the flash glyph table, 32 bytes per glyph.
  localparam logic [31:0] RANGE1_BASE   = 32'h0000_3400;
  localparam logic [15:0] RANGE1_TOP    = 16'h3400 + 16'h19b5;
  localparam logic [31:0] RANGE2_OFFSET = 32'h0000_4e00 - 32'h0000_19b5 - 32'd1;
  localparam int          GLYPH_SHIFT   = 5;

  localparam logic [7:0] BYTE_NEWLINE   = 8'h0a;
  localparam logic [7:0] BYTE_BACKSPACE = 8'h08;
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_DELETE    = 8'h7f;
  localparam logic [3:0] UTF8_LEAD3     = 4'he;

  localparam logic       OP_TEXT  = 1'b0;
  localparam logic       OP_CLEAR = 1'b1;

  localparam logic [1:0] KIND_ASCII = 2'd0;
  localparam logic [1:0] KIND_FLASH = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;

  localparam logic [1:0] UTF8_IDLE  = 2'd0;
  localparam logic [1:0] UTF8_LEAD  = 2'd1;
  localparam logic [1:0] UTF8_SECND = 2'd2;

  localparam logic [6:0] WIDE_GLYPH_SIZE = 7'd16;

  typedef struct packed {
    logic [4:0] column_count;
    logic [7:0] page_row;
    logic [1:0] utf8_count;
    logic       inverted_mode;
  } cursor_t;

  typedef struct packed {
    logic [1:0]  command_kind;
    logic [6:0]  ascii_index;
    logic [31:0] flash_address;
    logic [7:0]  x_position;
    logic [7:0]  y_page;
    logic [6:0]  glyph_height;
    logic [6:0]  glyph_width;
    logic        inverted;
  } command_t;

endpackage

>>> hdl/text_glyph_command_generator_core.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  operation, byte_value, string_start
// output    out        out_valid / out_stall  command fields, one word per glyph or clear
// config    in/out     APB write/read       highlight_line at byte address 0
//
// One byte word is taken per cycle unless in_stall is high; a result reaches the
// output register at the edge where its byte leaves the input register.
// The cursor and UTF-8 state advance in the same cycle that the byte leaves the
// input register, so back-to-back bytes see each other's updates.
// Synchronous reset clears the cursor, the UTF-8 count and highlight_line (to -1).
// A stalled output word holds only bytes that produce a result; bytes that
// produce none still pass while the output waits.
module text_glyph_command_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  byte_value,
  input  logic        string_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  command_kind,
  output logic [6:0]  ascii_index,
  output logic [31:0] flash_address,
  output logic [7:0]  x_position,
  output logic [7:0]  y_page,
  output logic [6:0]  glyph_height,
  output logic [6:0]  glyph_width,
  output logic        inverted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [8:0]  highlight_line;
  logic               cfg_write;

  logic               s1_valid;
  logic               s1_operation;
  logic [7:0]         s1_byte;
  logic               s1_start;

  tgcg_pkg::cursor_t  cursor;
  tgcg_pkg::cursor_t  cursor_next;
  logic [1:0][7:0]    utf8_bytes;
  logic [1:0][7:0]    utf8_bytes_next;
  logic               has_result;
  tgcg_pkg::command_t result;
  tgcg_pkg::command_t out_word;
  logic               proceed;
  logic               accept;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {{23{highlight_line[8]}}, highlight_line};

  always_ff @(posedge clk) begin
    if (rst) begin
      highlight_line <= -9'sd1;
    end else if (cfg_write) begin
      highlight_line <= pwdata[8:0];
    end
  end

  tgcg_engine u_engine (
    .cursor          (cursor),
    .utf8_bytes      (utf8_bytes),
    .highlight_line  (highlight_line),
    .operation       (s1_operation),
    .byte_value      (s1_byte),
    .string_start    (s1_start),
    .cursor_next     (cursor_next),
    .utf8_bytes_next (utf8_bytes_next),
    .has_result      (has_result),
    .result          (result)
  );

  assign proceed  = s1_valid && (!has_result || !out_valid || !out_stall);
  assign in_stall = s1_valid && !proceed;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      cursor    <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (proceed) begin
        s1_valid <= 1'b0;
      end
      if (proceed) begin
        cursor <= cursor_next;
      end
      if (proceed && has_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_operation <= operation;
      s1_byte      <= byte_value;
      s1_start     <= string_start;
    end
    if (proceed) begin
      utf8_bytes <= utf8_bytes_next;
    end
    if (proceed && has_result) begin
      out_word <= result;
    end
  end

  assign command_kind  = out_word.command_kind;
  assign ascii_index   = out_word.ascii_index;
  assign flash_address = out_word.flash_address;
  assign x_position    = out_word.x_position;
  assign y_page        = out_word.y_page;
  assign glyph_height  = out_word.glyph_height;
  assign glyph_width   = out_word.glyph_width;
  assign inverted      = out_word.inverted;

  a_utf8_count_range: assert property (@(posedge clk) disable iff (rst)
    cursor.utf8_count != 2'd3)
    else $error("UTF-8 count left its range");

  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    proceed && s1_operation == tgcg_pkg::OP_CLEAR
    |=> cursor.column_count == 5'd0 && cursor.page_row == 8'd0)
    else $error("clear did not home the cursor");

  a_fill_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_kind == tgcg_pkg::KIND_FILL
    |-> x_position == 8'd0 && y_page == 8'd0 && !inverted)
    else $error("fill word carries cursor data");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with nothing waiting");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    proceed && has_result |=> out_valid)
    else $error("result lost on the way to the output register");

endmodule

>>> hdl/tgcg_engine.sv
module tgcg_engine (
  input  tgcg_pkg::cursor_t        cursor,
  input  logic [1:0][7:0]          utf8_bytes,
  input  logic signed [8:0]        highlight_line,
  input  logic                     operation,
  input  logic [7:0]               byte_value,
  input  logic                     string_start,
  output tgcg_pkg::cursor_t        cursor_next,
  output logic [1:0][7:0]          utf8_bytes_next,
  output logic                     has_result,
  output tgcg_pkg::command_t       result
);

  tgcg_pkg::cursor_t wrapped;
  logic [15:0]       code_point;
  logic [31:0]       glyph_index;
  logic [7:0]        x_pos;

  always_comb begin
    wrapped = cursor;
    if (string_start) begin
      wrapped.inverted_mode = !highlight_line[8] && (highlight_line[7:0] == cursor.page_row);
    end
    // A full row wraps before the byte itself is handled.
    if (cursor.column_count >= tgcg_pkg::COLUMN_LIMIT) begin
      wrapped.column_count = '0;
      wrapped.page_row     = cursor.page_row + tgcg_pkg::PAGE_STEP;
    end
  end

  assign code_point = {utf8_bytes[0][3:0], utf8_bytes[1][5:0], byte_value[5:0]};
  assign glyph_index = (code_point > tgcg_pkg::RANGE1_TOP)
                     ? ({16'd0, code_point} - tgcg_pkg::RANGE2_OFFSET)
                     : ({16'd0, code_point} - tgcg_pkg::RANGE1_BASE);
  assign x_pos = 8'(1 + int'(wrapped.column_count) * tgcg_pkg::FONT_WIDTH);

  always_comb begin
    cursor_next     = cursor;
    utf8_bytes_next = utf8_bytes;
    has_result      = 1'b0;
    result          = '0;
    if (operation == tgcg_pkg::OP_CLEAR) begin
      cursor_next.column_count = '0;
      cursor_next.page_row     = '0;
      has_result               = 1'b1;
      result.command_kind      = tgcg_pkg::KIND_FILL;
    end else begin
      cursor_next         = wrapped;
      result.x_position   = x_pos;
      result.y_page       = wrapped.page_row;
      result.inverted     = wrapped.inverted_mode;
      priority if (cursor.utf8_count == tgcg_pkg::UTF8_LEAD) begin
        utf8_bytes_next[1]     = byte_value;
        cursor_next.utf8_count = tgcg_pkg::UTF8_SECND;
      end else if (cursor.utf8_count != tgcg_pkg::UTF8_IDLE) begin
        cursor_next.utf8_count   = tgcg_pkg::UTF8_IDLE;
        cursor_next.column_count = wrapped.column_count + 5'd2;
        has_result               = 1'b1;
        result.command_kind      = tgcg_pkg::KIND_FLASH;
        result.flash_address     = glyph_index << tgcg_pkg::GLYPH_SHIFT;
        result.glyph_height      = tgcg_pkg::WIDE_GLYPH_SIZE;
        result.glyph_width       = tgcg_pkg::WIDE_GLYPH_SIZE;
      end else if (byte_value[7:4] == tgcg_pkg::UTF8_LEAD3) begin
        utf8_bytes_next[0]     = byte_value;
        cursor_next.utf8_count = tgcg_pkg::UTF8_LEAD;
      end else if (byte_value == tgcg_pkg::BYTE_NEWLINE) begin
        cursor_next.column_count = '0;
        cursor_next.page_row     = wrapped.page_row + tgcg_pkg::PAGE_STEP;
      end else if (byte_value == tgcg_pkg::BYTE_BACKSPACE) begin
        cursor_next.column_count = wrapped.column_count;
      end else begin
        cursor_next.column_count = wrapped.column_count + 5'd1;
        if (byte_value >= tgcg_pkg::BYTE_SPACE && byte_value < tgcg_pkg::BYTE_DELETE) begin
          has_result          = 1'b1;
          result.command_kind = tgcg_pkg::KIND_ASCII;
          result.ascii_index  = 7'(byte_value - tgcg_pkg::BYTE_SPACE);
          result.glyph_height = 7'(tgcg_pkg::FONT_HEIGHT);
          result.glyph_width  = 7'(tgcg_pkg::FONT_WIDTH);
        end
      end
    end
  end

endmodule
